// File: src/clsr_pkg.sv
// ----------------------------------------------------------------------------
// clsr_pkg - shared types and constants
// Value width, generator constants and the sequencer state type for the
// combined congruential generator with shuffle table.
// ----------------------------------------------------------------------------
package clsr_pkg;

   localparam int VALUE_W = 31;
   localparam int MUL_W   = 16;
   localparam int FOLD_W  = 8;

   typedef logic [VALUE_W-1:0] value_type;

   // first generator: x * 40014 mod (2^31 - 85)
   localparam logic [MUL_W-1:0]   MUL_A  = 16'd40014;
   localparam logic [FOLD_W-1:0]  FOLD_A = 8'd85;
   localparam logic [VALUE_W-1:0] MOD_A  = 31'd2147483563;

   // second generator: x * 40692 mod (2^31 - 249)
   localparam logic [MUL_W-1:0]   MUL_B  = 16'd40692;
   localparam logic [FOLD_W-1:0]  FOLD_B = 8'd249;
   localparam logic [VALUE_W-1:0] MOD_B  = 31'd2147483399;

   localparam logic [VALUE_W-1:0] SEED_B    = 31'd123456789;
   localparam logic [VALUE_W-1:0] TOP_VALUE = 31'd2147483562;
   localparam logic [VALUE_W-1:0] SEED_ONE  = 31'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED,
      ST_WARM_MUL,
      ST_WARM_RED,
      ST_SETTLE,
      ST_STEP,
      ST_REDUCE,
      ST_COMBINE
   } clsr_state_type;

endpackage

// File: src/clsr_mcg_unit.sv
// ----------------------------------------------------------------------------
// clsr_mcg_unit - one multiplicative congruential step
// Registers x * MUL, then folds the high part back with 2^31 = FOLD (mod M)
// and finishes with one compare and subtract.
// ----------------------------------------------------------------------------
module clsr_mcg_unit
   import clsr_pkg::*;
#(
   parameter logic [MUL_W-1:0]   MUL_CONST  = MUL_A,
   parameter logic [FOLD_W-1:0]  FOLD_CONST = FOLD_A,
   parameter logic [VALUE_W-1:0] MOD_CONST  = MOD_A
) (
   input  logic      clock,
   input  value_type x,
   output value_type reduced
);

   localparam int PROD_W = VALUE_W + MUL_W;

   logic [PROD_W-1:0]         prod_ff;
   logic [PROD_W-1:0]         prod_in;
   logic [MUL_W+FOLD_W-1:0]   fold;
   logic [VALUE_W:0]          sum;

   assign prod_in = {{MUL_W{1'b0}}, x} * {{VALUE_W{1'b0}}, MUL_CONST};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // sum stays below twice the modulus, so one subtract completes the reduction
   assign fold = {{FOLD_W{1'b0}}, prod_ff[PROD_W-1:VALUE_W]}
                 * {{MUL_W{1'b0}}, FOLD_CONST};
   assign sum  = {{(VALUE_W+1-MUL_W-FOLD_W){1'b0}}, fold}
                 + {1'b0, prod_ff[VALUE_W-1:0]};

   always_comb begin
      if (sum >= {1'b0, MOD_CONST}) begin
         reduced = VALUE_W'(sum - {1'b0, MOD_CONST});
      end else begin
         reduced = sum[VALUE_W-1:0];
      end
   end

endmodule

// File: src/clsr_bin_index.sv
// ----------------------------------------------------------------------------
// clsr_bin_index - shuffle table index
// Divides the shuffle output by the bin width through an exact reciprocal
// multiply; the product is registered, so the index is valid the cycle after the value settles.
// ----------------------------------------------------------------------------
module clsr_bin_index
   import clsr_pkg::*;
#(
   parameter  int TABLE_SIZE = 32,
   localparam int IDX_W      = $clog2(TABLE_SIZE)
) (
   input  logic             clock,
   input  value_type        value,
   output logic [IDX_W-1:0] index
);

   localparam longint BIN_WIDTH = 64'd1 + longint'(TOP_VALUE) / TABLE_SIZE;
   localparam int     SHIFT     = VALUE_W + $clog2(BIN_WIDTH);
   localparam longint RECIP     = ((64'd1 << SHIFT) + BIN_WIDTH - 64'd1) / BIN_WIDTH;
   localparam int     RECIP_W   = 32;
   localparam int     PROD_W    = VALUE_W + RECIP_W;

   localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   assign prod_in = {{RECIP_W{1'b0}}, value} * {{VALUE_W{1'b0}}, RECIP_C};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign index = prod_ff[SHIFT +: IDX_W];

endmodule

// File: src/clsr_table_ram.sv
// ----------------------------------------------------------------------------
// clsr_table_ram - shuffle table storage
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module clsr_table_ram
   import clsr_pkg::*;
#(
   parameter  int DEPTH  = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  value_type         wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output value_type         rd_data
);

   value_type mem [DEPTH];
   value_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/combined_lcg_shuffle_rng.sv
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng - combined congruential generator with shuffle
// Two multiplicative congruential generators combined through a
// Bays-Durham shuffle table; one 31-bit draw per request transfer.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_valid/req_stall/req_restart): each transfer asks
//    for one draw. req_restart reseeds from the seed register first.
//  - Result channel (rsp_valid/rsp_stall/rsp_random_value): one transfer per
//    request, value 1..2147483562; divide by 2147483563 for a uniform deviate.
//  - csr_write_enable/csr_seed_magnitude: seed register, write while idle.
//  - Draw steps: accept, table read with both multiplies, reduction, then
//    combine and table write-back; the result is on the output register
//    the cycle after combine. The registered table read and the registered
//    multiplies set these steps. A new request waits until combine is done.
//  - Initialisation (restart, or first generator zero) adds a seed step,
//    TABLE_SIZE+8 warm-up steps of the first generator alone, each a multiply
//    and a reduce state, and a settle step.
//  - Reset: first generator zero, so the first draw always initialises and
//    fills the whole table before any read of it.
//  - A stalled result holds in the output register; the next request is still
//    taken, and its combine step waits until the register frees.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng
   import clsr_pkg::*;
#(
   parameter int TABLE_SIZE = 32
) (
   input  logic      clock,
   input  logic      reset,
   // request channel
   input  logic      req_valid,
   output logic      req_stall,
   input  logic      req_restart,
   // result channel
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output value_type rsp_random_value,
   // seed register
   input  logic      csr_write_enable,
   input  value_type csr_seed_magnitude
);

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int CNT_W = $clog2(TABLE_SIZE + 8);

   localparam logic [CNT_W-1:0] WARM_LAST  = CNT_W'(TABLE_SIZE + 7);
   localparam logic [CNT_W-1:0] TABLE_TOP  = CNT_W'(TABLE_SIZE);
   localparam logic [CNT_W-1:0] CNT_ZERO   = '0;

   clsr_state_type state_ff, state_in;

   value_type        seed_ff;
   value_type        g1_ff;      // first generator
   value_type        g2_ff;      // second generator
   value_type        so_ff;      // shuffle output
   logic [CNT_W-1:0] cnt_ff;     // warm-up step counter
   logic             rsp_valid_ff;
   value_type        rsp_value_ff;

   // sequencer controls
   logic             g_load_seed;
   logic             g1_load_red;
   logic             g2_load_red;
   logic             so_load_warm;
   logic             so_load_draw;
   logic             cnt_load;
   logic             cnt_dec;
   logic             tbl_we;
   logic [IDX_W-1:0] tbl_waddr;
   value_type        tbl_wdata;
   logic             tbl_re;

   value_type        red_a;
   value_type        red_b;
   value_type        tbl_rdata;
   logic [IDX_W-1:0] bin_idx;
   value_type        seed_eff;
   value_type        new_so;
   logic [VALUE_W:0] diff;
   logic [VALUE_W:0] diff_wrap;
   logic             out_busy;

   assign req_stall = (state_ff != ST_IDLE);
   assign out_busy  = rsp_valid_ff & rsp_stall;
   assign seed_eff  = (seed_ff == '0) ? SEED_ONE : seed_ff;

   // ---- datapath units ----
   clsr_mcg_unit #(
      .MUL_CONST  (MUL_A),
      .FOLD_CONST (FOLD_A),
      .MOD_CONST  (MOD_A)
   ) u_mcg_a (
      .clock   (clock),
      .x       (g1_ff),
      .reduced (red_a)
   );

   clsr_mcg_unit #(
      .MUL_CONST  (MUL_B),
      .FOLD_CONST (FOLD_B),
      .MOD_CONST  (MOD_B)
   ) u_mcg_b (
      .clock   (clock),
      .x       (g2_ff),
      .reduced (red_b)
   );

   // index is registered from so_ff; settle/idle cycles cover the lag
   clsr_bin_index #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_bin_index (
      .clock (clock),
      .value (so_ff),
      .index (bin_idx)
   );

   // read only in STEP, write only in WARM_RED / COMBINE: never the same cycle
   clsr_table_ram #(
      .DEPTH (TABLE_SIZE)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_en   (tbl_re),
      .rd_addr (bin_idx),
      .rd_data (tbl_rdata)
   );

   // new shuffle output: entry minus second generator, wrapped into 1..TOP
   assign diff      = {1'b0, tbl_rdata} - {1'b0, g2_ff};
   assign diff_wrap = diff + {1'b0, TOP_VALUE};
   assign new_so    = (tbl_rdata > g2_ff) ? diff[VALUE_W-1:0] : diff_wrap[VALUE_W-1:0];

   // ---- sequencer ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      g_load_seed  = 1'b0;
      g1_load_red  = 1'b0;
      g2_load_red  = 1'b0;
      so_load_warm = 1'b0;
      so_load_draw = 1'b0;
      cnt_load     = 1'b0;
      cnt_dec      = 1'b0;
      tbl_we       = 1'b0;
      tbl_waddr    = bin_idx;
      tbl_wdata    = g1_ff;
      tbl_re       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_restart || (g1_ff == '0)) begin
                  state_in = ST_SEED;
               end else begin
                  state_in = ST_STEP;
               end
            end
         end
         ST_SEED: begin
            g_load_seed = 1'b1;
            cnt_load    = 1'b1;
            state_in    = ST_WARM_MUL;
         end
         ST_WARM_MUL: begin
            state_in = ST_WARM_RED;
         end
         ST_WARM_RED: begin
            g1_load_red = 1'b1;
            // the last TABLE_SIZE warm-up steps fill the table top down
            if (cnt_ff < TABLE_TOP) begin
               tbl_we    = 1'b1;
               tbl_waddr = cnt_ff[IDX_W-1:0];
               tbl_wdata = red_a;
            end
            if (cnt_ff == CNT_ZERO) begin
               so_load_warm = 1'b1;
               state_in     = ST_SETTLE;
            end else begin
               cnt_dec  = 1'b1;
               state_in = ST_WARM_MUL;
            end
         end
         ST_SETTLE: begin
            state_in = ST_STEP;
         end
         ST_STEP: begin
            tbl_re   = 1'b1;
            state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            g1_load_red = 1'b1;
            g2_load_red = 1'b1;
            state_in    = ST_COMBINE;
         end
         ST_COMBINE: begin
            if (!out_busy) begin
               so_load_draw = 1'b1;
               tbl_we       = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---- state registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= SEED_ONE;
         g1_ff        <= '0;
         g2_ff        <= SEED_B;
         so_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            seed_ff <= csr_seed_magnitude;
         end
         if (g_load_seed) begin
            g1_ff <= seed_eff;
            g2_ff <= seed_eff;
         end else begin
            if (g1_load_red) begin
               g1_ff <= red_a;
            end
            if (g2_load_red) begin
               g2_ff <= red_b;
            end
         end
         if (so_load_warm) begin
            so_ff <= red_a;
         end else if (so_load_draw) begin
            so_ff <= new_so;
         end
         if (cnt_load) begin
            cnt_ff <= WARM_LAST;
         end else if (cnt_dec) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
         if (so_load_draw) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (so_load_draw) begin
         rsp_value_ff <= new_so;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_value_ff;

   // ---- checks ----
   a_combine_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMBINE && !out_busy) |=> rsp_valid)
      else $error("combine step did not load the result register");

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_random_value != '0 && rsp_random_value <= TOP_VALUE))
      else $error("result outside 1..TOP_VALUE");

   a_gen_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REDUCE) |=> (g1_ff < MOD_A && g2_ff < MOD_B))
      else $error("generator step not reduced below its modulus");

   a_held_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (state_ff != ST_IDLE || $stable(rsp_random_value)))
      else $error("stalled result overwritten");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for combined_lcg_shuffle_rng
// A directed table of seeds and restarts, then random phases, each under a
// fresh seed. Every request transfer runs through a local model of the two
// congruential generators and the shuffle table, and each returned value is
// compared with the oldest predicted value.
// ----------------------------------------------------------------------------
module testbench
   import clsr_pkg::*;
();

   localparam int     TABLE_SIZE   = 32;
   localparam int     CYCLE_LIMIT  = 1000000;
   localparam int     DRAIN_CYCLES = 120;   // > one initialisation plus a draw
   localparam int     PHASES       = 14;
   localparam int     PHASE_ITEMS  = 112;
   // Schrage decomposition: modulus = multiplier * quotient + remainder
   localparam longint QUO_A     = 53668;
   localparam longint REM_A     = 12211;
   localparam longint QUO_B     = 52774;
   localparam longint REM_B     = 3791;
   localparam longint BIN_WIDTH = 1 + longint'(TOP_VALUE) / TABLE_SIZE;
   // seed equal to the first modulus: first generator collapses to zero
   localparam value_type SEED_COLLAPSE = 31'd2147483563;
   // ... and the single draw it gives: 0 - (seed * 40692 mod MOD_B) + TOP_VALUE
   localparam value_type DRAW_COLLAPSE = 31'd2140810074;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_RUNS
   } stall_mode_type;

   typedef struct packed {
      logic      load_seed;   // write the seed register first (while idle)
      value_type seed;
      logic      restart;
      logic      known;       // value below is typed in, not predicted
      value_type want;
   } draw_row_type;

   localparam int DIRECTED_ROWS = 22;
   localparam draw_row_type DIRECTED [DIRECTED_ROWS] = '{
      // first draw after reset: seed register still at its reset value of one
      '{1'b0, 31'd0,          1'b0, 1'b0, 31'd0},
      '{1'b0, 31'd0,          1'b0, 1'b0, 31'd0},
      '{1'b0, 31'd0,          1'b1, 1'b0, 31'd0},
      '{1'b0, 31'd0,          1'b0, 1'b0, 31'd0},
      // zero seed stands in for one
      '{1'b1, 31'd0,          1'b1, 1'b0, 31'd0},
      '{1'b0, 31'd0,          1'b0, 1'b0, 31'd0},
      // all-ones seed, above both moduli
      '{1'b1, 31'h7FFFFFFF,   1'b1, 1'b0, 31'd0},
      '{1'b0, 31'd0,          1'b0, 1'b0, 31'd0},
      '{1'b0, 31'd0,          1'b0, 1'b0, 31'd0},
      // collapsing seed: every draw re-initialises and repeats the same value
      '{1'b1, SEED_COLLAPSE,  1'b1, 1'b1, DRAW_COLLAPSE},
      '{1'b0, 31'd0,          1'b0, 1'b1, DRAW_COLLAPSE},
      '{1'b0, 31'd0,          1'b0, 1'b1, DRAW_COLLAPSE},
      // either side of the first modulus
      '{1'b1, 31'd2147483562, 1'b1, 1'b0, 31'd0},
      '{1'b0, 31'd0,          1'b0, 1'b0, 31'd0},
      '{1'b1, 31'd2147483564, 1'b1, 1'b0, 31'd0},
      '{1'b0, 31'd0,          1'b0, 1'b0, 31'd0},
      // new seed without restart must not disturb the running sequence
      '{1'b1, 31'd123456789,  1'b0, 1'b0, 31'd0},
      '{1'b0, 31'd0,          1'b0, 1'b0, 31'd0},
      '{1'b0, 31'd0,          1'b1, 1'b0, 31'd0},
      '{1'b1, 31'h2AAAAAAA,   1'b1, 1'b0, 31'd0},
      '{1'b1, 31'h55555555,   1'b1, 1'b0, 31'd0},
      '{1'b0, 31'd0,          1'b0, 1'b0, 31'd0}
   };

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_stall;
   logic      req_restart;
   logic      rsp_valid;
   logic      rsp_stall;
   value_type rsp_random_value;
   logic      csr_write_enable;
   value_type csr_seed_magnitude;

   // model state
   value_type seed_reg;
   longint    gen_a;
   longint    gen_b;
   longint    shuf_out;
   longint    shuf_table [TABLE_SIZE];

   value_type      pending_values [$];
   int             errors      = 0;
   int             cycle_count = 0;
   int             burst_left  = 0;
   int             gap_max     = 6;
   stall_mode_type stall_mode  = STALL_NONE;
   int             mode_left   = 0;
   int             run_left    = 0;

   combined_lcg_shuffle_rng #(
      .TABLE_SIZE(TABLE_SIZE)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_restart        (req_restart),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_random_value   (rsp_random_value),
      .csr_write_enable   (csr_write_enable),
      .csr_seed_magnitude (csr_seed_magnitude)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // x * mul mod modulus without overflow (Schrage)
   function automatic longint congruential_step(input longint x, input longint mul,
                                                input longint quo, input longint rem,
                                                input longint modulus);
      longint k;
      longint v;
      k = x / quo;
      v = mul * (x - k * quo) - k * rem;
      if (v < 0)
         v += modulus;
      return v;
   endfunction

   // Advance the model by one draw and return the value the block should give.
   function automatic value_type predict_draw(input logic restart);
      longint start;
      longint pick;
      if (restart || gen_a == 0) begin
         start = longint'(seed_reg);
         if (start < 1)
            start = 1;
         gen_a = start;
         gen_b = start;
         // 8 discarded warm-up steps, then the table fills from the top down
         for (int i = TABLE_SIZE + 7; i >= 0; i--) begin
            gen_a = congruential_step(gen_a, MUL_A, QUO_A, REM_A, MOD_A);
            if (i < TABLE_SIZE)
               shuf_table[i] = gen_a;
         end
         shuf_out = shuf_table[0];
      end
      gen_a = congruential_step(gen_a, MUL_A, QUO_A, REM_A, MOD_A);
      gen_b = congruential_step(gen_b, MUL_B, QUO_B, REM_B, MOD_B);
      pick = shuf_out / BIN_WIDTH;
      if (pick < 0)
         pick = 0;
      if (pick >= TABLE_SIZE)
         pick = TABLE_SIZE - 1;
      shuf_out = shuf_table[pick] - gen_b;
      shuf_table[pick] = gen_a;
      if (shuf_out < 1)
         shuf_out += longint'(TOP_VALUE);
      return value_type'(shuf_out);
   endfunction

   // Seed writes only once the block has gone quiet: all results back, then
   // a margin so the final combine and write-back are well out of the way.
   task automatic load_seed(input value_type seed);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_values.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      csr_write_enable   <= 1'b1;
      csr_seed_magnitude <= seed;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      seed_reg = seed;
   endtask

   // One request transfer. The sender runs in bursts; a gap of random length
   // (possibly none) opens between bursts so idle cycles hit every phase.
   task automatic issue_draw(input logic restart, input logic known, input value_type want);
      int        gap;
      value_type predicted;
      if (burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_restart <= restart;
      do
         @(posedge clock);
      while (req_stall);
      predicted = predict_draw(restart);
      pending_values.push_back(known ? want : predicted);
   endtask

   // Receiver stall pattern: switches between no stall, light, heavy and long
   // alternating runs, holding each mode for a span drawn anew at each switch.
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         mode_left  <= $urandom_range(50, 400);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: begin
            if (run_left == 0) begin
               rsp_stall <= ~rsp_stall;
               run_left  <= $urandom_range(1, 12);
            end else begin
               run_left <= run_left - 1;
            end
         end
      endcase
   end

   // Result check against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_values.size() == 0) begin
            errors++;
            $display("%0t: unexpected result transfer, value %0d", $time,
                     rsp_random_value);
         end else if (rsp_random_value !== pending_values[0]) begin
            errors++;
            $display("%0t: random_value mismatch: expected %0d, actual %0d", $time,
                     pending_values[0], rsp_random_value);
            void'(pending_values.pop_front());
         end else begin
            void'(pending_values.pop_front());
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   initial begin
      value_type seed;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_restart        = 1'b0;
      rsp_stall          = 1'b0;
      csr_write_enable   = 1'b0;
      csr_seed_magnitude = '0;

      // model reset
      seed_reg = SEED_ONE;
      gen_a    = 0;
      gen_b    = longint'(SEED_B);
      shuf_out = 0;
      foreach (shuf_table[i])
         shuf_table[i] = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (DIRECTED[r]) begin
         if (DIRECTED[r].load_seed)
            load_seed(DIRECTED[r].seed);
         issue_draw(DIRECTED[r].restart, DIRECTED[r].known, DIRECTED[r].want);
      end

      // random phases, each under its own seed; every fourth with no sender gaps
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       seed = '0;
            1:       seed = 31'h7FFFFFFF;
            2:       seed = SEED_COLLAPSE;
            3:       seed = TOP_VALUE;
            4:       seed = SEED_ONE;
            default: seed = ($urandom_range(0, 2) == 0) ? value_type'($urandom_range(1, 1000))
                                                         : value_type'($urandom);
         endcase
         gap_max = (p % 4 == 3) ? 0 : $urandom_range(2, 9);
         load_seed(seed);
         for (int n = 0; n < PHASE_ITEMS; n++)
            issue_draw($urandom_range(0, 11) == 0, 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (pending_values.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pending_values.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

// File: combined_lcg_shuffle_rng.f
src/clsr_pkg.sv
src/clsr_mcg_unit.sv
src/clsr_bin_index.sv
src/clsr_table_ram.sv
src/combined_lcg_shuffle_rng.sv
sim/testbench.sv
